@@ hdl/scc_pkg.sv @@
// Package for the segment conflict two-coloring block.
// Holds shared constants, the sequencer state type and the color codes.
// No dependencies.
package scc_pkg;

   localparam int unsigned MAX_SEGMENTS_DEF = 1024;
   localparam int unsigned COORD_W = 32;

   typedef enum logic [1:0] {
      COLOR_NONE = 2'd0,
      COLOR_ONE  = 2'd1,
      COLOR_TWO  = 2'd2,
      COLOR_BAD  = 2'd3
   } color_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_START,
      ST_POP,
      ST_NODE,
      ST_SCAN,
      ST_TEST,
      ST_RESULT
   } state_type;

endpackage

@@ hdl/scc_conflict.sv @@
// Registered conflict test between the current node segment and a scanned one.
// Depends on scc_pkg for the coordinate width.
module scc_conflict (
   input  logic                              clock,
   input  logic signed [scc_pkg::COORD_W-1:0] node_left,
   input  logic signed [scc_pkg::COORD_W-1:0] node_right,
   input  logic signed [scc_pkg::COORD_W-1:0] node_height,
   input  logic signed [scc_pkg::COORD_W-1:0] other_left,
   input  logic signed [scc_pkg::COORD_W-1:0] other_right,
   input  logic signed [scc_pkg::COORD_W-1:0] other_height,
   output logic                              hit
);
   import scc_pkg::*;

   logic signed [COORD_W-1:0] lo;
   logic signed [COORD_W-1:0] hi;
   logic hit_in;
   logic hit_ff;

   always_comb begin
      lo = (node_left > other_left) ? node_left : other_left;
      hi = (node_right < other_right) ? node_right : other_right;
      hit_in = (node_height == other_height) && (lo <= hi);
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   assign hit = hit_ff;

endmodule

@@ hdl/segment_conflict_two_coloring.sv @@
// Top level of the segment conflict two-coloring block.
// Holds the segment, color and stack memories and the walk sequencer.
// Depends on scc_pkg and scc_conflict.
//
// Segments arrive as request beats, one per cycle while the block is loading, and are written to memory.
// A beat with last_segment set starts the evaluation; the request side is not
// ready until its single response beat has been taken. Beats beyond
// MAX_SEGMENTS are dropped and set the overflowed flag of the response.
// The walk sweeps the color memory first, then for every colored node scans
// all n stored segments, each neighbor candidate passing through the single
// memory read port and the registered conflict unit.
// The response stays on rsp_ while the receiver stalls; after it is taken the
// block returns to loading. Reset (synchronous, active high) empties the set;
// the color memory is cleared by the sweep before each walk.
module segment_conflict_two_coloring #(
   parameter int unsigned MAX_SEGMENTS = scc_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [scc_pkg::COORD_W-1:0] req_left_end,
   input  logic signed [scc_pkg::COORD_W-1:0] req_right_end,
   input  logic signed [scc_pkg::COORD_W-1:0] req_height,
   input  logic                              req_last_segment,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_two_colorable,
   output logic                              rsp_overflowed
);
   import scc_pkg::*;

   localparam int unsigned IW = $clog2(MAX_SEGMENTS);
   localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);

   logic signed [COORD_W-1:0] left_mem   [MAX_SEGMENTS];
   logic signed [COORD_W-1:0] right_mem  [MAX_SEGMENTS];
   logic signed [COORD_W-1:0] height_mem [MAX_SEGMENTS];
   color_type                 color_mem  [MAX_SEGMENTS];
   logic [IW-1:0]             stack_mem  [MAX_SEGMENTS];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic over_ff, over_in;
   logic ok_ff, ok_in;
   logic [CW-1:0] start_ff, start_in;
   logic [CW-1:0] other_ff, other_in;
   logic [CW-1:0] top_ff, top_in;
   logic [IW-1:0] node_ff, node_in;
   color_type node_color_ff, node_color_in;
   logic phase_ff, phase_in;

   logic signed [COORD_W-1:0] nl_ff, nr_ff, nh_ff;
   logic signed [COORD_W-1:0] rl_ff, rr_ff, rh_ff;
   color_type rc_ff;
   logic [IW-1:0] rs_ff;
   logic hit;

   logic [IW-1:0] seg_addr;
   logic [IW-1:0] color_waddr;
   logic color_we;
   color_type color_wdata;
   logic stack_we;
   logic [IW-1:0] stack_wdata;
   logic [IW-1:0] stack_waddr;
   logic [IW-1:0] stack_raddr;
   logic seg_we;
   logic node_load;

   scc_conflict u_conflict (
      .clock(clock),
      .node_left(nl_ff), .node_right(nr_ff), .node_height(nh_ff),
      .other_left(rl_ff), .other_right(rr_ff), .other_height(rh_ff),
      .hit(hit)
   );

   always_ff @(posedge clock) begin
      if (seg_we) begin
         left_mem[count_ff[IW-1:0]]   <= req_left_end;
         right_mem[count_ff[IW-1:0]]  <= req_right_end;
         height_mem[count_ff[IW-1:0]] <= req_height;
      end
      rl_ff <= left_mem[seg_addr];
      rr_ff <= right_mem[seg_addr];
      rh_ff <= height_mem[seg_addr];
      if (color_we) begin
         color_mem[color_waddr] <= color_wdata;
      end
      rc_ff <= color_mem[seg_addr];
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      rs_ff <= stack_mem[stack_raddr];
      if (node_load) begin
         nl_ff <= rl_ff;
         nr_ff <= rr_ff;
         nh_ff <= rh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         over_ff  <= 1'b0;
         ok_ff    <= 1'b1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         over_ff  <= over_in;
         ok_ff    <= ok_in;
      end
      start_ff      <= start_in;
      other_ff      <= other_in;
      top_ff        <= top_in;
      node_ff       <= node_in;
      node_color_ff <= node_color_in;
   end

   // Each candidate passes through SCAN and then TEST. The first SCAN cycle issues the
   // memory read, the second SCAN cycle (phase set) registers the conflict test,
   // and TEST uses the hit bit together with the candidate's color.
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      over_in       = over_ff;
      ok_in         = ok_ff;
      start_in      = start_ff;
      other_in      = other_ff;
      top_in        = top_ff;
      node_in       = node_ff;
      node_color_in = node_color_ff;
      phase_in      = 1'b0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      seg_we        = 1'b0;
      seg_addr      = other_ff[IW-1:0];
      color_we      = 1'b0;
      color_waddr   = other_ff[IW-1:0];
      color_wdata   = COLOR_NONE;
      stack_we      = 1'b0;
      stack_waddr   = top_ff[IW-1:0];
      stack_wdata   = other_ff[IW-1:0];
      stack_raddr   = IW'(top_ff - CW'(1));
      node_load     = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < MAX_C) begin
                  seg_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  over_in = 1'b1;
               end
               if (req_last_segment) begin
                  state_in = ST_CLEAR;
                  other_in = '0;
                  ok_in    = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            color_we = 1'b1;
            if (other_ff == MAX_C - CW'(1)) begin
               state_in = ST_START;
               start_in = '0;
               other_in = '0;
            end else begin
               other_in = other_ff + CW'(1);
            end
         end
         ST_START: begin
            seg_addr = start_ff[IW-1:0];
            if (start_ff >= count_ff) begin
               state_in = ST_RESULT;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (rc_ff != COLOR_NONE) begin
               start_in = start_ff + CW'(1);
            end else begin
               color_we    = 1'b1;
               color_waddr = start_ff[IW-1:0];
               color_wdata = COLOR_ONE;
               stack_we    = 1'b1;
               stack_waddr = '0;
               stack_wdata = start_ff[IW-1:0];
               top_in      = CW'(1);
               state_in    = ST_POP;
            end
         end
         ST_POP: begin
            if (top_ff == '0) begin
               start_in = start_ff + CW'(1);
               state_in = ST_START;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               node_in  = rs_ff;
               top_in   = top_ff - CW'(1);
               state_in = ST_NODE;
            end
         end
         ST_NODE: begin
            seg_addr = node_ff;
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               node_load     = 1'b1;
               node_color_in = rc_ff;
               other_in      = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (other_ff >= count_ff) begin
               state_in = ST_POP;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if ((other_ff[IW-1:0] != node_ff) && hit) begin
               if (rc_ff == COLOR_NONE) begin
                  color_we    = 1'b1;
                  color_wdata = (node_color_ff == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;
                  if (top_ff < MAX_C) begin
                     stack_we = 1'b1;
                     top_in   = top_ff + CW'(1);
                  end
               end else if (rc_ff == node_color_ff) begin
                  ok_in    = 1'b0;
                  state_in = ST_RESULT;
               end
            end
            other_in = other_ff + CW'(1);
            if (state_in != ST_RESULT) begin
               state_in = ST_SCAN;
            end
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_LOAD;
               count_in = '0;
               over_in  = 1'b0;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp_two_colorable = ok_ff;
   assign rsp_overflowed    = over_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_C) else $error("segment count beyond capacity");
   a_top_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP || state_ff == ST_SCAN || state_ff == ST_TEST) |-> top_ff <= MAX_C)
      else $error("stack beyond capacity");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req_ready) else $error("ready while busy");
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (count_ff == '0 && !over_ff))
      else $error("set not cleared after response");
`endif

endmodule

@@ sim/tb_top.sv @@
// Testbench for segment_conflict_two_coloring: sends segment sets and checks each
// yes/no result against a predictor that keeps its own copy of the segment store.
// Depends on scc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
   import scc_pkg::*;

   localparam int unsigned CAP = MAX_SEGMENTS_DEF;
   localparam longint unsigned CYCLE_LIMIT = 20000000;
   localparam int unsigned VQ_DEPTH = 16;

   typedef struct packed {
      logic two_colorable;
      logic overflowed;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_left_end = '0;
   logic signed [COORD_W-1:0] req_right_end = '0;
   logic signed [COORD_W-1:0] req_height = '0;
   logic req_last_segment = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_two_colorable;
   logic rsp_overflowed;

   logic signed [COORD_W-1:0] seg_lo [CAP];
   logic signed [COORD_W-1:0] seg_hi [CAP];
   logic signed [COORD_W-1:0] seg_lvl [CAP];
   color_type paint [CAP];
   int unsigned dfs_stack [CAP];
   int unsigned stored_count = 0;
   logic dropped_any = 1'b0;

   verdict_type verdict_fifo [VQ_DEPTH];
   int unsigned vf_wr = 0;
   int unsigned vf_rd = 0;
   int errors = 0;
   int items_sent = 0;
   int hold_off_cycles = 0;
   longint unsigned cycles = 0;

   segment_conflict_two_coloring DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(string line);
      $display("MISMATCH %s at cycle %0d", line, cycles);
      errors++;
   endtask

   function automatic int unsigned verdicts_pending();
      return vf_wr - vf_rd;
   endfunction

   function automatic bit segments_clash(int unsigned p, int unsigned q);
      logic signed [COORD_W-1:0] lo, hi;
      if (seg_lvl[p] != seg_lvl[q]) return 1'b0;
      lo = (seg_lo[p] > seg_lo[q]) ? seg_lo[p] : seg_lo[q];
      hi = (seg_hi[p] < seg_hi[q]) ? seg_hi[p] : seg_hi[q];
      return lo <= hi;
   endfunction

   function automatic bit set_is_two_colorable();
      int unsigned depth, node;
      for (int unsigned s = 0; s < stored_count; s++) begin
         if (paint[s] != COLOR_NONE) continue;
         paint[s] = COLOR_ONE;
         dfs_stack[0] = s;
         depth = 1;
         while (depth > 0) begin
            depth = depth - 1;
            node = dfs_stack[depth];
            for (int unsigned o = 0; o < stored_count; o++) begin
               if (o == node || !segments_clash(node, o)) continue;
               if (paint[o] == COLOR_NONE) begin
                  paint[o] = (paint[node] == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;
                  if (depth < CAP) begin
                     dfs_stack[depth] = o;
                     depth = depth + 1;
                  end
               end else if (paint[o] == paint[node]) begin
                  return 1'b0;
               end
            end
         end
      end
      return 1'b1;
   endfunction

   task automatic record_segment(logic signed [31:0] l, logic signed [31:0] r,
                                 logic signed [31:0] h, logic last);
      verdict_type v;
      if (stored_count < CAP) begin
         seg_lo[stored_count] = l;
         seg_hi[stored_count] = r;
         seg_lvl[stored_count] = h;
         paint[stored_count] = COLOR_NONE;
         stored_count++;
      end else begin
         dropped_any = 1'b1;
      end
      if (last) begin
         v.two_colorable = set_is_two_colorable();
         v.overflowed = dropped_any;
         verdict_fifo[vf_wr[3:0]] = v;
         vf_wr = vf_wr + 1;
         for (int i = 0; i < CAP; i++) paint[i] = COLOR_NONE;
         stored_count = 0;
         dropped_any = 1'b0;
      end
   endtask

   task automatic send_segment(logic signed [31:0] l, logic signed [31:0] r,
                               logic signed [31:0] h, logic last);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_left_end = l;
      req_right_end = r;
      req_height = h;
      req_last_segment = last;
      do @(posedge clock); while (!(req_valid && req_ready));
      record_segment(l, r, h, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req_valid = 1'b0;
      req_last_segment = 1'b0;
   endtask

   task automatic wait_all_verdicts();
      idle_sender();
      while (verdicts_pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Response side: random stalls, with an optional long hold-off.
   initial begin
      int w;
      verdict_type want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            w = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         end
         if (w > 0) begin
            rsp_ready = 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (verdicts_pending() == 0) begin
            report_mismatch("unexpected result beat");
         end else begin
            want = verdict_fifo[vf_rd[3:0]];
            vf_rd = vf_rd + 1;
            if (rsp_two_colorable !== want.two_colorable)
               report_mismatch($sformatf("two_colorable: got %0b expected %0b",
                                         rsp_two_colorable, want.two_colorable));
            if (rsp_overflowed !== want.overflowed)
               report_mismatch($sformatf("overflowed: got %0b expected %0b",
                                         rsp_overflowed, want.overflowed));
         end
         @(negedge clock);
      end
   end

   task automatic test_small_shapes();
      send_segment(5, 9, 0, 1'b1);
      send_segment(1, 4, 7, 1'b0);
      send_segment(1, 4, 7, 1'b1);
      send_segment(0, 10, 3, 1'b0);
      send_segment(5, 15, 3, 1'b0);
      send_segment(8, 20, 3, 1'b1);
      send_segment(0, 3, 1, 1'b0);
      send_segment(3, 6, 1, 1'b0);
      send_segment(6, 9, 1, 1'b0);
      send_segment(0, 3, 2, 1'b1);
      wait_all_verdicts();
   endtask

   task automatic test_reversed_and_extremes();
      send_segment(9, 2, 4, 1'b0);
      send_segment(0, 10, 4, 1'b0);
      send_segment(3, 3, 4, 1'b1);
      send_segment(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
      send_segment(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0);
      send_segment(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
      send_segment(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
      send_segment(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1);
      send_segment(-1, 0, -1, 1'b0);
      send_segment(0, -1, -1, 1'b0);
      send_segment(-1, -1, -1, 1'b0);
      send_segment(-5, 5, -1, 1'b1);
      wait_all_verdicts();
   endtask

   // An odd cycle at the front keeps the walk short on full sets.
   task automatic send_full_set(int total);
      for (int i = 0; i < total; i++) begin
         if (i < 3) send_segment(0, 10, 5, 1'b0);
         else send_segment(i, i, 100 + i, i == total - 1);
      end
   endtask

   // The set fills the store, then two more beats are dropped, the last one too.
   task automatic test_capacity();
      send_full_set(CAP + 2);
      wait_all_verdicts();
   endtask

   task automatic send_random_set(int n);
      logic signed [31:0] l, r, h;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) begin
         if (mode == 0) begin
            l = $urandom;
            r = $urandom;
            h = $urandom;
         end else begin
            l = $urandom_range(0, 40) - 20;
            r = l + $urandom_range(0, 12) - 2;
            h = (mode == 1) ? $urandom : $urandom_range(0, 2) - 1;
         end
         send_segment(l, r, h, i == n - 1);
      end
   endtask

   task automatic test_random_sets();
      int n;
      while (items_sent < 1850) begin
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
         send_random_set(n);
         if ($urandom_range(0, 40) == 0) wait_all_verdicts();
      end
      wait_all_verdicts();
   endtask

   task automatic test_receiver_hold_off();
      hold_off_cycles = 3000;
      for (int k = 0; k < 6; k++) send_random_set($urandom_range(2, 6));
      wait_all_verdicts();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_small_shapes();
      test_reversed_and_extremes();
      test_capacity();
      test_receiver_hold_off();
      test_random_sets();
      repeat (50) @(negedge clock);
      if (verdicts_pending() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", verdicts_pending()));
      end
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
